// ===== rtl/core/slen_pkg.sv =====
// slen_pkg: shared constants, codes and types for the sorted list engine.
// No dependencies; used by slen_cell and sorted_list_engine_top.
package slen_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int FIDX_W   = 4;
    localparam int RIDX_W   = 4;
    localparam int RVAL_W   = 32;
    localparam int ECNT_W   = 5;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    // broadcast to every cell
    typedef struct packed {
        logic                          ins_en;
        logic                          rem_en;
        logic signed [VALUE_WIDTH-1:0] value;
    } slen_cmd_t;

    // what one cell reports back
    typedef struct packed {
        logic lt;
        logic eq;
    } slen_flags_t;

endpackage

// ===== rtl/core/slen_cell.sv =====
// slen_cell: one position of the sorted list; holds a value, compares it with
// the broadcast key and shifts from its left or right neighbour. Uses slen_pkg.
module slen_cell (
    input  logic                                   clk,
    input  logic                                   occupied,
    input  slen_pkg::slen_cmd_t                    cmd,
    input  logic                                   left_lt,
    input  logic signed [slen_pkg::VALUE_WIDTH-1:0] left_val,
    input  logic signed [slen_pkg::VALUE_WIDTH-1:0] right_val,
    output logic signed [slen_pkg::VALUE_WIDTH-1:0] val,
    output slen_pkg::slen_flags_t                  flags
);

    logic signed [slen_pkg::VALUE_WIDTH-1:0] val_reg;
    logic signed [slen_pkg::VALUE_WIDTH-1:0] val_next;

    always_comb
    begin
        flags.lt = occupied && (val_reg < cmd.value);
        flags.eq = occupied && (val_reg == cmd.value);
        val_next = val_reg;
        if (cmd.ins_en && !flags.lt)
        begin
            val_next = left_lt ? cmd.value : left_val;
        end
        else if (cmd.rem_en && !flags.lt)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

// ===== rtl/core/sorted_list_engine_top.sv =====
// sorted_list_engine_top: ascending list of signed values held in a row of
// slen_cell instances, with a registered result stage. Uses slen_pkg, slen_cell.
//
//  channel  dir  handshake               payload
//  s_axis   in   s_axis_tvalid/tready    op, item_value, item_index
//  m_axis   out  m_axis_tvalid/tready    status, found_index, read_value, entry_count
//
// One transaction per cycle unless a result stalls; results appear the next cycle.
// The period is set by the value compare in every cell plus the shift select.
// rst_n clears the entry count and the result valid; cell contents are not reset.
// A stalled result holds; a new transaction is taken in the cycle it is consumed.
module sorted_list_engine_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [1:0] op, [33:2] item_value, [37:34] item_index, [39:38] zero
    input  logic [slen_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [1:0] status, [5:2] found_index, [37:6] read_value, [42:38] entry_count,
    // [47:43] zero
    output logic [slen_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int VW = slen_pkg::VALUE_WIDTH;
    localparam int N  = slen_pkg::DEPTH;

    slen_pkg::op_t                  op;
    logic signed [VW-1:0]           item_value;
    logic [slen_pkg::RIDX_W-1:0]    item_index;
    logic                           accept;

    logic [slen_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                           out_valid_reg, out_valid_next;
    slen_pkg::status_t              status_reg, status_next;
    logic [slen_pkg::FIDX_W-1:0]    fidx_reg, fidx_next;
    logic [slen_pkg::RVAL_W-1:0]    rval_reg, rval_next;

    slen_pkg::slen_cmd_t            cmd;
    logic signed [VW-1:0]           vals [N];
    slen_pkg::slen_flags_t          flags [N];
    logic [N-1:0]                   occ;
    logic [N-1:0]                   hit;
    logic                           full;
    logic                           found;
    logic [slen_pkg::IDX_W-1:0]     hit_idx;

    assign op         = slen_pkg::op_t'(s_axis_tdata[1:0]);
    assign item_value = s_axis_tdata[33:2];
    assign item_index = s_axis_tdata[37:34];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign full          = (count_reg == slen_pkg::CNT_W'(N));

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            logic                 l_lt;
            logic signed [VW-1:0] l_val;
            logic signed [VW-1:0] r_val;

            assign occ[g] = (slen_pkg::CNT_W'(g) < count_reg);

            if (g == 0)
            begin : g_first
                assign l_lt  = 1'b1;
                assign l_val = item_value;
            end
            else
            begin : g_mid
                assign l_lt  = flags[g-1].lt;
                assign l_val = vals[g-1];
            end

            if (g == N - 1)
            begin : g_last
                assign r_val = vals[g];
            end
            else
            begin : g_notlast
                assign r_val = vals[g+1];
            end

            // first equal element sits just after the last smaller one
            assign hit[g] = flags[g].eq && l_lt;

            slen_cell u_cell (
                .clk       (clk),
                .occupied  (occ[g]),
                .cmd       (cmd),
                .left_lt   (l_lt),
                .left_val  (l_val),
                .right_val (r_val),
                .val       (vals[g]),
                .flags     (flags[g])
            );
        end
    endgenerate

    assign found = |hit;

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < N; i++)
        begin
            if (hit[i])
            begin
                hit_idx = hit_idx | slen_pkg::IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        cmd.value  = item_value;
        cmd.ins_en = accept && (op == slen_pkg::OP_INSERT) && !full;
        cmd.rem_en = accept && (op == slen_pkg::OP_REMOVE) && found;

        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        fidx_next      = fidx_reg;
        rval_next      = rval_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = slen_pkg::ST_OK;
            fidx_next      = '0;
            rval_next      = '0;
            case (op)
                slen_pkg::OP_INSERT:
                begin
                    if (full)
                    begin
                        status_next = slen_pkg::ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                slen_pkg::OP_REMOVE:
                begin
                    if (found)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        status_next = slen_pkg::ST_NOT_FOUND;
                    end
                end
                slen_pkg::OP_FIND:
                begin
                    if (found)
                    begin
                        fidx_next = slen_pkg::FIDX_W'(hit_idx);
                    end
                    else
                    begin
                        status_next = slen_pkg::ST_NOT_FOUND;
                    end
                end
                slen_pkg::OP_READ:
                begin
                    if (slen_pkg::CNT_W'(item_index) < count_reg)
                    begin
                        rval_next = slen_pkg::RVAL_W'(vals[item_index]);
                    end
                    else
                    begin
                        status_next = slen_pkg::ST_BAD_INDEX;
                    end
                end
                default:
                begin
                    status_next = slen_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        fidx_reg   <= fidx_next;
        rval_reg   <= rval_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0,
                            slen_pkg::ECNT_W'(count_reg),
                            rval_reg,
                            fidx_reg,
                            status_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= slen_pkg::CNT_W'(N))
        else $error("entry count above depth");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == slen_pkg::OP_INSERT) && full |=> count_reg == $past(count_reg))
        else $error("insert into full list changed the count");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_axis_tvalid)
        else $error("accepted transaction gave no result");

    a_count_reported: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[42:38] == slen_pkg::ECNT_W'(count_reg))
        else $error("reported count differs from held count");

    a_hit_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit))
        else $error("more than one first-equal position");

endmodule
